### hdl/pbmp_pkg.sv
// Package: shared types, codes and defaults of the background mode picker.
`default_nettype none
package pbmp_pkg;

   localparam int PIXELS_DEF = 4096;
   localparam int SLOTS_DEF  = 8;

   localparam int THR_W    = 17;
   localparam int NOISE_W  = 16;
   localparam int CSR_IDXW = 2;

   localparam logic [THR_W-1:0] THR_RESET = 17'd49152;
   localparam logic [THR_W-1:0] THR_ONE   = 17'd65536;

   localparam logic [CSR_IDXW-1:0] REG_THRESHOLD   = 2'd0;
   localparam logic [CSR_IDXW-1:0] REG_NOISE_LIMIT = 2'd1;

   localparam int MAC_W   = 26;
   localparam int ACC_W   = 68;

   typedef enum logic [2:0] {
      STAT_COUNTED = 3'd0,
      STAT_NEW     = 3'd1,
      STAT_DROPPED = 3'd2,
      STAT_MOST    = 3'd3,
      STAT_DISSIM  = 3'd4,
      STAT_NONE    = 3'd5
   } status_type;

   typedef struct packed {
      logic [23:0] color;
      logic [15:0] count;
      logic [31:0] stamp;
   } slot_type;

   typedef struct packed {
      logic en;
      logic clr;
      logic hi;
   } mac_ctl_type;

endpackage
`default_nettype wire

### hdl/pbmp_ifs.sv
// Interfaces: request and response channels of the background mode picker.
`default_nettype none
interface pbmp_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [11:0] pixel_index;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   modport source (output valid, mode, pixel_index, red, green, blue, input ready);
   modport sink   (input valid, mode, pixel_index, red, green, blue, output ready);
endinterface

interface pbmp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_red;
   logic [7:0]  out_green;
   logic [7:0]  out_blue;
   logic [2:0]  status;
   logic [31:0] replaced_total;
   modport source (output valid, out_red, out_green, out_blue, status, replaced_total,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, status, replaced_total,
                   output ready);
endinterface
`default_nettype wire

### hdl/pbmp_mac.sv
// Shared multiply-accumulate unit used by the generate sequencer.
`default_nettype none
module pbmp_mac (
   input  wire logic                        clock,
   input  wire pbmp_pkg::mac_ctl_type       ctl,
   input  wire logic [pbmp_pkg::MAC_W-1:0]  a,
   input  wire logic [pbmp_pkg::MAC_W-1:0]  b,
   output logic      [pbmp_pkg::ACC_W-1:0]  acc_ff
);
   logic [2*pbmp_pkg::MAC_W-1:0] prod;
   logic [pbmp_pkg::ACC_W-1:0]   prod_ext;
   logic [pbmp_pkg::ACC_W-1:0]   addend;
   logic [pbmp_pkg::ACC_W-1:0]   acc_in;

   assign prod     = a * b;
   assign prod_ext = pbmp_pkg::ACC_W'(prod);
   // high partial product lands one operand width up
   assign addend   = ctl.hi ? (prod_ext << pbmp_pkg::MAC_W) : prod_ext;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.en) begin
         acc_in = ctl.clr ? addend : acc_ff + addend;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end
endmodule
`default_nettype wire

### hdl/pbmp_store.sv
// Slot memory: one word per pixel slot, one write port, one registered read port.
`default_nettype none
module pbmp_store #(
   parameter int DEPTH = pbmp_pkg::PIXELS_DEF * pbmp_pkg::SLOTS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               we,
   input  wire logic [AW-1:0]      waddr,
   input  wire pbmp_pkg::slot_type wdata,
   input  wire logic [AW-1:0]      raddr,
   output pbmp_pkg::slot_type      rdata_ff
);
   pbmp_pkg::slot_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end
endmodule
`default_nettype wire

### hdl/pixel_background_mode_picker.sv
// Top level: per-pixel background color picker by temporal mode.
// Add item: the slots are scanned through the memory read port, then the table is updated.
// Generate item: a first slot scan picks the most frequent entry; when one exists, a second
//   scan runs the shared multiply-accumulate unit ten steps for each entry above noise_limit.
// One item in work at a time; a finished result waits in the output register.
// Reset (synchronous, active high) resets counters and control registers, then a clearing pass
//   writes every slot word of the memory empty while req_ch.ready stays low.
`default_nettype none
module pixel_background_mode_picker #(
   parameter int PIXELS = pbmp_pkg::PIXELS_DEF,
   parameter int SLOTS  = pbmp_pkg::SLOTS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   pbmp_req_if.sink                            req_ch,
   pbmp_rsp_if.source                          rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic [pbmp_pkg::CSR_IDXW-1:0]  csr_index,
   input  wire logic [pbmp_pkg::THR_W-1:0]     csr_wdata
);
   localparam int DEPTH = PIXELS * SLOTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = $clog2(SLOTS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   typedef enum logic [12:0] {
      S_CLEAR = 13'b0000000000001,
      S_IDLE  = 13'b0000000000010,
      S_ARD   = 13'b0000000000100,
      S_ACHK  = 13'b0000000001000,
      S_AWR   = 13'b0000000010000,
      S_G1RD  = 13'b0000000100000,
      S_G1CHK = 13'b0000001000000,
      S_GPRE  = 13'b0000010000000,
      S_G2RD  = 13'b0000100000000,
      S_G2CHK = 13'b0001000000000,
      S_G2MUL = 13'b0010000000000,
      S_GEND  = 13'b0100000000000,
      S_FIN   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // item registers
   logic [SW-1:0]  slot_ff, slot_in;
   logic [AW-1:0]  base_ff, base_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [23:0]    color_ff, color_in;
   logic [3:0]     step_ff, step_in;

   // add scan
   logic           empty_vld_ff, empty_vld_in;
   logic [SW-1:0]  empty_slot_ff, empty_slot_in;
   logic           found_ff, found_in;
   logic [SW-1:0]  found_slot_ff, found_slot_in;
   logic [15:0]    found_cnt_ff, found_cnt_in;
   logic [31:0]    found_stamp_ff, found_stamp_in;

   // generate scan
   logic               best_vld_ff, best_vld_in;
   pbmp_pkg::slot_type best_ff, best_in;
   logic               cand_vld_ff, cand_vld_in;
   pbmp_pkg::slot_type cand_ff, cand_in;
   pbmp_pkg::slot_type cur_ff, cur_in;
   logic [17:0]    nb_ff, nb_in;
   logic [7:0]     tn_ff, tn_in;
   logic [50:0]    tnb_ff, tnb_in;
   logic [17:0]    dot_ff, dot_in;
   logic [17:0]    na_ff, na_in;
   logic [35:0]    d2_ff, d2_in;

   // result and global state
   logic [23:0]            res_color_ff, res_color_in;
   pbmp_pkg::status_type   res_status_ff, res_status_in;
   logic [31:0]            stamp_ff, stamp_in;
   logic [31:0]            replaced_ff, replaced_in;
   logic [pbmp_pkg::THR_W-1:0]   thr_ff, thr_in;
   logic [pbmp_pkg::NOISE_W-1:0] noise_ff, noise_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [23:0]            o_color_ff, o_color_in;
   pbmp_pkg::status_type   o_status_ff, o_status_in;
   logic [31:0]            o_repl_ff, o_repl_in;

   // memory and shared unit
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   pbmp_pkg::slot_type mem_wdata;
   logic [AW-1:0]      mem_raddr;
   pbmp_pkg::slot_type mem_q;

   pbmp_pkg::mac_ctl_type        mac_ctl;
   logic [pbmp_pkg::MAC_W-1:0]   mac_a, mac_b;
   logic [pbmp_pkg::ACC_W-1:0]   acc;

   logic req_xfer;
   logic in_range;
   logic qual;
   logic last_slot;
   logic dissim;
   logic fin_load;
   logic [1:0] sq_lane;

   pbmp_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock    (clock),
      .we       (mem_we),
      .waddr    (mem_waddr),
      .wdata    (mem_wdata),
      .raddr    (mem_raddr),
      .rdata_ff (mem_q)
   );

   pbmp_mac u_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .a      (mac_a),
      .b      (mac_b),
      .acc_ff (acc)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign in_range     = 32'(req_ch.pixel_index) < 32'(PIXELS);
   assign last_slot    = (slot_ff == LAST_SLOT);
   assign mem_raddr    = base_ff + AW'(slot_ff);
   // an entry takes part in generate when occupied and above the noise floor
   assign qual         = (mem_q.count != 16'd0) && (mem_q.count > noise_ff);
   assign fin_load     = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ch.ready);
   // color lane of the norm steps: steps 3, 4, 5 take lanes 0, 1, 2
   assign sq_lane      = step_ff[1:0] + 2'd1;

   // similarity verdict, valid in the last multiply step
   always_comb begin
      if (na_ff == 18'd0 || nb_ff == 18'd0 || thr_ff > pbmp_pkg::THR_ONE) begin
         // a zero norm means similarity one; a limit above one makes every color dissimilar
         dissim = thr_ff > pbmp_pkg::THR_ONE;
      end else if (thr_ff == '0) begin
         dissim = 1'b0;
      end else begin
         dissim = {d2_ff, 32'd0} < acc;
      end
   end

   // operand select for the shared multiply-accumulate unit
   always_comb begin
      mac_ctl = '0;
      mac_a   = '0;
      mac_b   = '0;
      if (state_ff == S_GPRE) begin
         case (step_ff)
            4'd0, 4'd1, 4'd2: begin
               // norm of the most frequent color
               mac_ctl = '{en: 1'b1, clr: (step_ff == 4'd0), hi: 1'b0};
               mac_a   = 26'(best_ff.color[8*step_ff[1:0] +: 8]);
               mac_b   = 26'(best_ff.color[8*step_ff[1:0] +: 8]);
            end
            4'd3: begin
               mac_ctl = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
               mac_a   = 26'(thr_ff);
               mac_b   = 26'(thr_ff);
            end
            4'd4: begin
               mac_ctl = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
               mac_a   = 26'(nb_ff);
               mac_b   = acc[25:0];
            end
            4'd5: begin
               mac_ctl = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
               mac_a   = 26'(nb_ff);
               mac_b   = 26'(tn_ff);
            end
            default: begin
               mac_ctl = '0;
            end
         endcase
      end else if (state_ff == S_G2MUL) begin
         case (step_ff)
            4'd0, 4'd1, 4'd2: begin
               // dot product with the most frequent color
               mac_ctl = '{en: 1'b1, clr: (step_ff == 4'd0), hi: 1'b0};
               mac_a   = 26'(cur_ff.color[8*step_ff[1:0] +: 8]);
               mac_b   = 26'(best_ff.color[8*step_ff[1:0] +: 8]);
            end
            4'd3, 4'd4, 4'd5: begin
               mac_ctl = '{en: 1'b1, clr: (step_ff == 4'd3), hi: 1'b0};
               mac_a   = 26'(cur_ff.color[8*sq_lane +: 8]);
               mac_b   = 26'(cur_ff.color[8*sq_lane +: 8]);
            end
            4'd6: begin
               mac_ctl = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
               mac_a   = 26'(dot_ff);
               mac_b   = 26'(dot_ff);
            end
            4'd7: begin
               mac_ctl = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
               mac_a   = 26'(na_ff);
               mac_b   = tnb_ff[25:0];
            end
            4'd8: begin
               mac_ctl = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
               mac_a   = 26'(na_ff);
               mac_b   = 26'(tnb_ff[50:26]);
            end
            default: begin
               mac_ctl = '0;
            end
         endcase
      end
   end

   // memory write: clearing pass or add update
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
      end else if (state_ff == S_AWR) begin
         if (found_ff) begin
            // keep the first-seen stamp of a counted color
            mem_we          = 1'b1;
            mem_waddr       = base_ff + AW'(found_slot_ff);
            mem_wdata.color = color_ff;
            mem_wdata.count = (found_cnt_ff == 16'hFFFF) ? found_cnt_ff
                                                         : found_cnt_ff + 16'd1;
            mem_wdata.stamp = found_stamp_ff;
         end else if (empty_vld_ff) begin
            mem_we          = 1'b1;
            mem_waddr       = base_ff + AW'(empty_slot_ff);
            mem_wdata.color = color_ff;
            mem_wdata.count = 16'd1;
            mem_wdata.stamp = stamp_ff;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      slot_in        = slot_ff;
      base_in        = base_ff;
      clr_in         = clr_ff;
      color_in       = color_ff;
      step_in        = step_ff;
      empty_vld_in   = empty_vld_ff;
      empty_slot_in  = empty_slot_ff;
      found_in       = found_ff;
      found_slot_in  = found_slot_ff;
      found_cnt_in   = found_cnt_ff;
      found_stamp_in = found_stamp_ff;
      best_vld_in    = best_vld_ff;
      best_in        = best_ff;
      cand_vld_in    = cand_vld_ff;
      cand_in        = cand_ff;
      cur_in         = cur_ff;
      nb_in          = nb_ff;
      tn_in          = tn_ff;
      tnb_in         = tnb_ff;
      dot_in         = dot_ff;
      na_in          = na_ff;
      d2_in          = d2_ff;
      res_color_in   = res_color_ff;
      res_status_in  = res_status_ff;
      stamp_in       = stamp_ff;
      replaced_in    = replaced_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      o_color_in     = o_color_ff;
      o_status_in    = o_status_ff;
      o_repl_in      = o_repl_ff;

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               color_in     = {req_ch.blue, req_ch.green, req_ch.red};
               base_in      = AW'(32'(req_ch.pixel_index) * SLOTS);
               slot_in      = '0;
               empty_vld_in = 1'b0;
               found_in     = 1'b0;
               best_vld_in  = 1'b0;
               cand_vld_in  = 1'b0;
               res_color_in = '0;
               if (!in_range) begin
                  // out-of-range pixel: report without touching the table
                  res_status_in = req_ch.mode ? pbmp_pkg::STAT_NONE : pbmp_pkg::STAT_DROPPED;
                  state_in      = S_FIN;
               end else begin
                  state_in = req_ch.mode ? S_G1RD : S_ARD;
               end
            end
         end
         S_ARD: begin
            state_in = S_ACHK;
         end
         S_ACHK: begin
            if (mem_q.count == 16'd0) begin
               if (!empty_vld_ff) begin
                  empty_vld_in  = 1'b1;
                  empty_slot_in = slot_ff;
               end
            end else if (!found_ff && mem_q.color == color_ff) begin
               found_in       = 1'b1;
               found_slot_in  = slot_ff;
               found_cnt_in   = mem_q.count;
               found_stamp_in = mem_q.stamp;
            end
            slot_in  = slot_ff + SW'(1);
            state_in = last_slot ? S_AWR : S_ARD;
         end
         S_AWR: begin
            res_color_in = '0;
            if (found_ff) begin
               res_status_in = pbmp_pkg::STAT_COUNTED;
            end else if (empty_vld_ff) begin
               res_status_in = pbmp_pkg::STAT_NEW;
               stamp_in      = stamp_ff + 32'd1;
            end else begin
               res_status_in = pbmp_pkg::STAT_DROPPED;
            end
            state_in = S_FIN;
         end
         S_G1RD: begin
            state_in = S_G1CHK;
         end
         S_G1CHK: begin
            // keep the last entry in generate order
            if (qual && (!best_vld_ff || mem_q.count > best_ff.count ||
                         (mem_q.count == best_ff.count && mem_q.stamp <= best_ff.stamp))) begin
               best_vld_in = 1'b1;
               best_in     = mem_q;
            end
            slot_in = slot_ff + SW'(1);
            if (last_slot) begin
               step_in  = '0;
               state_in = S_GPRE;
            end else begin
               state_in = S_G1RD;
            end
         end
         S_GPRE: begin
            step_in = step_ff + 4'd1;
            if (!best_vld_ff) begin
               state_in = S_GEND;
            end else begin
               case (step_ff)
                  4'd3: nb_in  = acc[17:0];
                  4'd4: tn_in  = acc[33:26];
                  4'd6: begin
                     tnb_in   = acc[50:0];
                     slot_in  = '0;
                     state_in = S_G2RD;
                  end
                  default: begin
                     tnb_in = tnb_ff;
                  end
               endcase
            end
         end
         S_G2RD: begin
            state_in = S_G2CHK;
         end
         S_G2CHK: begin
            if (qual) begin
               cur_in   = mem_q;
               step_in  = '0;
               state_in = S_G2MUL;
            end else begin
               slot_in  = slot_ff + SW'(1);
               state_in = last_slot ? S_GEND : S_G2RD;
            end
         end
         S_G2MUL: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd3: dot_in = acc[17:0];
               4'd6: na_in  = acc[17:0];
               4'd7: d2_in  = acc[35:0];
               4'd9: begin
                  // keep the first dissimilar entry in generate order
                  if (dissim && (!cand_vld_ff || cur_ff.count < cand_ff.count ||
                                 (cur_ff.count == cand_ff.count &&
                                  cur_ff.stamp > cand_ff.stamp))) begin
                     cand_vld_in = 1'b1;
                     cand_in     = cur_ff;
                  end
                  slot_in  = slot_ff + SW'(1);
                  state_in = last_slot ? S_GEND : S_G2RD;
               end
               default: begin
                  d2_in = d2_ff;
               end
            endcase
         end
         S_GEND: begin
            if (!best_vld_ff) begin
               res_status_in = pbmp_pkg::STAT_NONE;
               res_color_in  = '0;
            end else if (cand_vld_ff) begin
               res_status_in = pbmp_pkg::STAT_DISSIM;
               res_color_in  = cand_ff.color;
            end else begin
               res_status_in = pbmp_pkg::STAT_MOST;
               res_color_in  = best_ff.color;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            // hold until the output register is free
            if (fin_load) begin
               if (res_status_ff == pbmp_pkg::STAT_DISSIM) begin
                  replaced_in = replaced_ff + 32'd1;
               end
               rsp_valid_in = 1'b1;
               o_color_in   = res_color_ff;
               o_status_in  = res_status_ff;
               o_repl_in    = (res_status_ff == pbmp_pkg::STAT_DISSIM) ? replaced_ff + 32'd1
                                                                       : replaced_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      thr_in   = thr_ff;
      noise_in = noise_ff;
      if (csr_we) begin
         case (csr_index)
            pbmp_pkg::REG_THRESHOLD:   thr_in   = csr_wdata;
            pbmp_pkg::REG_NOISE_LIMIT: noise_in = csr_wdata[pbmp_pkg::NOISE_W-1:0];
            default:                   thr_in   = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         stamp_ff     <= '0;
         replaced_ff  <= '0;
         thr_ff       <= pbmp_pkg::THR_RESET;
         noise_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         stamp_ff     <= stamp_in;
         replaced_ff  <= replaced_in;
         thr_ff       <= thr_in;
         noise_ff     <= noise_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff        <= slot_in;
      base_ff        <= base_in;
      color_ff       <= color_in;
      empty_vld_ff   <= empty_vld_in;
      empty_slot_ff  <= empty_slot_in;
      found_ff       <= found_in;
      found_slot_ff  <= found_slot_in;
      found_cnt_ff   <= found_cnt_in;
      found_stamp_ff <= found_stamp_in;
      best_vld_ff    <= best_vld_in;
      best_ff        <= best_in;
      cand_vld_ff    <= cand_vld_in;
      cand_ff        <= cand_in;
      cur_ff         <= cur_in;
      nb_ff          <= nb_in;
      tn_ff          <= tn_in;
      tnb_ff         <= tnb_in;
      dot_ff         <= dot_in;
      na_ff          <= na_in;
      d2_ff          <= d2_in;
      res_color_ff   <= res_color_in;
      res_status_ff  <= res_status_in;
      o_color_ff     <= o_color_in;
      o_status_ff    <= o_status_in;
      o_repl_ff      <= o_repl_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_red        = o_color_ff[7:0];
   assign rsp_ch.out_green      = o_color_ff[15:8];
   assign rsp_ch.out_blue       = o_color_ff[23:16];
   assign rsp_ch.status         = o_status_ff;
   assign rsp_ch.replaced_total = o_repl_ff;

`ifndef SYNTH
   a_xfer_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> state_ff == S_IDLE)
      else $error("request transfer outside idle");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && rsp_valid_ff && !rsp_ch.ready) |=> state_ff == S_FIN)
      else $error("result dropped while output stalled");

   a_replaced_step: assert property (@(posedge clock) disable iff (reset)
      (replaced_ff != $past(replaced_ff)) |->
         $past(fin_load && res_status_ff == pbmp_pkg::STAT_DISSIM))
      else $error("replaced counter moved without a dissimilar result");
`endif

endmodule
`default_nettype wire

### tb/pbmp_checker.sv
// Checker: predicts each background picker result and compares it with the DUT output.
`default_nettype none
module pbmp_checker #(
   parameter int PIXELS = pbmp_pkg::PIXELS_DEF,
   parameter int SLOTS  = pbmp_pkg::SLOTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pbmp_req_if                                req,
   pbmp_rsp_if                                rsp,
   input  wire logic                          csr_we,
   input  wire logic [pbmp_pkg::CSR_IDXW-1:0] csr_index,
   input  wire logic [pbmp_pkg::THR_W-1:0]    csr_wdata,
   output int                                 fail_count,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0]           r;
      logic [7:0]           g;
      logic [7:0]           b;
      pbmp_pkg::status_type st;
      logic [31:0]          total;
   } bg_pick_type;

   bg_pick_type picks_due[$];
   logic [23:0] tbl_color [PIXELS*SLOTS];
   logic [15:0] tbl_count [PIXELS*SLOTS];
   logic [31:0] tbl_stamp [PIXELS*SLOTS];
   logic [31:0] next_stamp;
   logic [31:0] replaced;
   logic [pbmp_pkg::THR_W-1:0]   thr;
   logic [pbmp_pkg::NOISE_W-1:0] noise;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // Cosine below threshold, decided exactly on squares; colors packed {b,g,r}.
   function automatic bit dissimilar(logic [23:0] c1, logic [23:0] c2);
      logic [79:0] dot, na, nb, lhs, rhs, t;
      dot = '0; na = '0; nb = '0;
      for (int k = 0; k < 3; k++) begin
         dot += c1[8*k +: 8] * c2[8*k +: 8];
         na  += c1[8*k +: 8] * c1[8*k +: 8];
         nb  += c2[8*k +: 8] * c2[8*k +: 8];
      end
      if (na == 0 || nb == 0)
         return thr > pbmp_pkg::THR_ONE;
      if (thr == 0)
         return 1'b0;
      t   = 80'(thr);
      lhs = (dot * dot) << 32;
      rhs = t * t * na * nb;
      return lhs < rhs;
   endfunction

   // Generate order: count ascending, later stamp first, then lower slot.
   function automatic bit goes_first(int a, int b);
      if (tbl_count[a] != tbl_count[b])
         return tbl_count[a] < tbl_count[b];
      if (tbl_stamp[a] != tbl_stamp[b])
         return tbl_stamp[a] > tbl_stamp[b];
      return a < b;
   endfunction

   function automatic bg_pick_type pick_background(logic m, logic [11:0] pix, logic [23:0] c);
      bg_pick_type res;
      logic [23:0] chosen;
      logic [23:0] most;
      int          base, empty, n, j, e;
      bit          found;
      int          order [SLOTS];
      chosen = '0;
      base   = pix * SLOTS;
      if (m == 1'b0) begin
         res.st = pbmp_pkg::STAT_DROPPED;
         empty  = -1;
         found  = 0;
         if (pix < PIXELS) begin
            for (int s = 0; s < SLOTS; s++) begin
               e = base + s;
               if (tbl_count[e] == 0) begin
                  if (empty < 0) empty = s;
               end else if (!found && tbl_color[e] == c) begin
                  if (tbl_count[e] != 16'hFFFF) tbl_count[e]++;
                  found = 1;
               end
            end
            if (found) begin
               res.st = pbmp_pkg::STAT_COUNTED;
            end else if (empty >= 0) begin
               tbl_color[base+empty] = c;
               tbl_count[base+empty] = 16'd1;
               tbl_stamp[base+empty] = next_stamp;
               next_stamp++;
               res.st = pbmp_pkg::STAT_NEW;
            end
         end
      end else begin
         res.st = pbmp_pkg::STAT_NONE;
         n = 0;
         if (pix < PIXELS) begin
            for (int s = 0; s < SLOTS; s++) begin
               e = base + s;
               if (tbl_count[e] != 0 && tbl_count[e] > noise) begin
                  for (j = n; j > 0 && goes_first(e, order[j-1]); j--)
                     order[j] = order[j-1];
                  order[j] = e;
                  n++;
               end
            end
            if (n > 0) begin
               most   = tbl_color[order[n-1]];
               chosen = most;
               res.st = pbmp_pkg::STAT_MOST;
               for (int i = 0; i < n; i++) begin
                  if (dissimilar(tbl_color[order[i]], most)) begin
                     chosen = tbl_color[order[i]];
                     replaced++;
                     res.st = pbmp_pkg::STAT_DISSIM;
                     break;
                  end
               end
            end
         end
      end
      res.r     = chosen[7:0];
      res.g     = chosen[15:8];
      res.b     = chosen[23:16];
      res.total = replaced;
      return res;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      bg_pick_type want;
      if (reset) begin
         for (int i = 0; i < PIXELS*SLOTS; i++) tbl_count[i] = '0;
         next_stamp = '0;
         replaced   = '0;
         thr        = pbmp_pkg::THR_RESET;
         noise      = '0;
         picks_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               pbmp_pkg::REG_THRESHOLD:   thr   = csr_wdata;
               pbmp_pkg::REG_NOISE_LIMIT: noise = csr_wdata[pbmp_pkg::NOISE_W-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (picks_due.size() == 0) begin
               report("result with no item waiting", rsp.status, -1);
            end else begin
               want = picks_due.pop_front();
               if (rsp.out_red !== want.r)   report("out_red", rsp.out_red, want.r);
               if (rsp.out_green !== want.g) report("out_green", rsp.out_green, want.g);
               if (rsp.out_blue !== want.b)  report("out_blue", rsp.out_blue, want.b);
               if (rsp.status !== want.st)   report("status", rsp.status, want.st);
               if (rsp.replaced_total !== want.total)
                  report("replaced_total", rsp.replaced_total, want.total);
            end
         end
         if (req.valid && req.ready)
            picks_due.push_back(pick_background(req.mode, req.pixel_index,
                                                {req.blue, req.green, req.red}));
      end
      pending = picks_due.size();
   end
endmodule
`default_nettype wire

### tb/tb_pixel_background_mode_picker.sv
// Testbench top: stimulus, config phases and verdict for the background mode picker.
`default_nettype none
module tb_pixel_background_mode_picker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [pbmp_pkg::CSR_IDXW-1:0] REG_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 200000;   // covers the slot clearing pass after reset
   localparam bit MODE_ADD = 1'b0;
   localparam bit MODE_GEN = 1'b1;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [pbmp_pkg::CSR_IDXW-1:0] csr_index;
   logic [pbmp_pkg::THR_W-1:0]    csr_wdata;

   pbmp_req_if req_ch ();
   pbmp_rsp_if rsp_ch ();

   int  fail_count;
   int  pending;
   bit  req_fire, rsp_fire;
   bit  calm;                 // when set, neither side idles
   int  rsp_stall;
   int  items_sent, gens_sent;
   int  idle_cycles;

   pixel_background_mode_picker DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pbmp_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Sample transfers at the rising edge; stimulus reacts at the next falling edge.
   always @(posedge clock) begin
      req_fire <= req_ch.valid && req_ch.ready;
      rsp_fire <= rsp_ch.valid && rsp_ch.ready;
   end

   // Response side: draw a stall after every transfer, then hold ready low for it.
   always @(negedge clock) begin
      if (rsp_fire)
         rsp_stall = calm ? 0 : $urandom_range(0, 17);
      if (rsp_stall > 0) begin
         rsp_ch.ready = 1'b0;
         rsp_stall--;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   // Watchdog: end the run when nothing transfers for too long.
   always @(posedge clock) begin
      if (req_fire || rsp_fire)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results missing",
                  IDLE_LIMIT, pending);
         $display("** pixel_background_mode_picker: FAILED **");
         $finish;
      end
   end

   // Present one item after a random gap and hold it until the transfer.
   task automatic send(bit m, logic [11:0] pix, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.mode        = m;
      req_ch.pixel_index = pix;
      req_ch.red         = r;
      req_ch.green       = g;
      req_ch.blue        = b;
      req_ch.valid       = 1'b1;
      do @(negedge clock); while (!req_fire);
      items_sent++;
      if (m == MODE_GEN) gens_sent++;
   endtask

   // Drop valid and wait until every expected result is back.
   task automatic drain();
      req_ch.valid = 1'b0;
      wait (pending == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [pbmp_pkg::CSR_IDXW-1:0] idx,
                            logic [pbmp_pkg::THR_W-1:0] val);
      drain();
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   logic [23:0] seed_colors [8] = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
                                    24'hFF0000, 24'h00FFFF, 24'h030201, 24'h204080};
   logic [23:0] palette [10];
   logic [11:0] hot_pix [12];
   logic [pbmp_pkg::THR_W-1:0]   phase_thr   [6] = '{17'd49152, 17'd65536, 17'd0,
                                                     17'd65535, 17'd1, 17'd32768};
   logic [pbmp_pkg::NOISE_W-1:0] phase_noise [6] = '{16'd0, 16'd0, 16'd1, 16'd2, 16'd0,
                                                     16'd65535};

   initial begin
      logic [23:0] c;
      logic [11:0] p;
      bit          m;
      req_ch.valid = 1'b0;
      req_ch.mode = 1'b0;
      req_ch.pixel_index = '0;
      req_ch.red = '0;
      req_ch.green = '0;
      req_ch.blue = '0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      calm = 1'b0;
      rsp_stall = 0;
      items_sent = 0;
      gens_sent = 0;
      idle_cycles = 0;
      reset = 1'b1;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed: fill pixel 0 with eight colors, black among them, then overflow it.
      foreach (seed_colors[i])
         send(MODE_ADD, 12'd0, seed_colors[i][7:0], seed_colors[i][15:8],
              seed_colors[i][23:16]);
      send(MODE_ADD, 12'd0, 8'd9, 8'd9, 8'd9);          // table full, dropped
      send(MODE_ADD, 12'd0, 8'hFF, 8'hFF, 8'hFF);
      send(MODE_ADD, 12'd0, 8'hFF, 8'hFF, 8'hFF);
      send(MODE_ADD, 12'd0, 8'hFF, 8'h00, 8'h00);
      send(MODE_GEN, 12'd0, 8'hAA, 8'h55, 8'hAA);
      send(MODE_GEN, 12'd4095, 8'h00, 8'h00, 8'h00);    // empty table
      send(MODE_ADD, 12'd4095, 8'h00, 8'h00, 8'hFF);
      send(MODE_GEN, 12'd4095, 8'hFF, 8'hFF, 8'hFF);
      send(MODE_ADD, 12'd4095, 8'h00, 8'h00, 8'hFE);
      send(MODE_ADD, 12'd4095, 8'h00, 8'h00, 8'hFE);
      send(MODE_GEN, 12'd4095, 8'h00, 8'h00, 8'h00);
      write_reg(pbmp_pkg::REG_THRESHOLD, pbmp_pkg::THR_ONE);
      send(MODE_GEN, 12'd0, 8'h00, 8'h00, 8'h00);
      write_reg(pbmp_pkg::REG_NOISE_LIMIT, 17'd1);
      send(MODE_GEN, 12'd0, 8'h00, 8'h00, 8'h00);
      write_reg(pbmp_pkg::REG_NOISE_LIMIT, 17'd65535);
      send(MODE_GEN, 12'd0, 8'h00, 8'h00, 8'h00);       // nothing qualifies
      write_reg(pbmp_pkg::REG_THRESHOLD, 17'd0);
      write_reg(pbmp_pkg::REG_NOISE_LIMIT, 17'd0);
      write_reg(REG_UNUSED, 17'h1FFFF);                 // must be ignored
      send(MODE_GEN, 12'd0, 8'h00, 8'h00, 8'h00);
      write_reg(pbmp_pkg::REG_THRESHOLD, 17'h1FFFF);    // limit above one
      send(MODE_GEN, 12'd0, 8'h00, 8'h00, 8'h00);
      write_reg(pbmp_pkg::REG_THRESHOLD, pbmp_pkg::THR_RESET);

      // Build one count at full rate, then probe it right at the noise limit.
      calm = 1'b1;
      repeat (20) send(MODE_ADD, 12'd100, 8'd10, 8'd20, 8'd30);
      send(MODE_ADD, 12'd100, 8'd200, 8'd10, 8'd10);
      send(MODE_GEN, 12'd100, 8'd0, 8'd0, 8'd0);
      write_reg(pbmp_pkg::REG_NOISE_LIMIT, 17'd19);
      send(MODE_GEN, 12'd100, 8'd0, 8'd0, 8'd0);
      write_reg(pbmp_pkg::REG_NOISE_LIMIT, 17'd20);
      send(MODE_GEN, 12'd100, 8'd0, 8'd0, 8'd0);
      calm = 1'b0;

      // Random phases: a few hot pixels fill up, with a palette so colors repeat.
      foreach (hot_pix[i])
         hot_pix[i] = (i == 0) ? 12'd0 : (i == 1) ? 12'd4095 : 12'($urandom_range(0, 4095));
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 4) begin
            phase_thr[ph]   = 17'($urandom_range(0, 65536));
            phase_noise[ph] = 16'($urandom_range(0, 3));
         end
         write_reg(pbmp_pkg::REG_THRESHOLD, phase_thr[ph]);
         write_reg(pbmp_pkg::REG_NOISE_LIMIT, 17'(phase_noise[ph]));
         calm = (ph == 2);
         foreach (palette[i])
            palette[i] = (i == 0) ? 24'h000000 : 24'($urandom());
         for (int n = 0; n < 100; n++) begin
            if (ph == 1 && n == 50) drain();    // hold off until the block is empty
            m = ($urandom_range(0, 3) == 0) ? MODE_GEN : MODE_ADD;
            p = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                            : hot_pix[4'($urandom_range(0, 11))];
            c = ($urandom_range(0, 6) == 0) ? 24'($urandom())
                                            : palette[4'($urandom_range(0, 9))];
            send(m, p, c[7:0], c[15:8], c[23:16]);
         end
      end

      drain();
      repeat (200) @(negedge clock);
      $display("run covered %0d items (%0d generate), six config phases, noise-limit edges",
               items_sent, gens_sent);
      $display("and full tables, empty tables and zero-norm colors; %0d mismatches",
               fail_count);
      if (fail_count == 0)
         $display("** pixel_background_mode_picker: PASSED **");
      else
         $display("** pixel_background_mode_picker: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
hdl/pbmp_pkg.sv
hdl/pbmp_ifs.sv
hdl/pbmp_mac.sv
hdl/pbmp_store.sv
hdl/pixel_background_mode_picker.sv
tb/pbmp_checker.sv
tb/tb_pixel_background_mode_picker.sv
